FILE: sv/pwgd_pkg.sv
// ----------------------------------------------------------------------------
// pwgd_pkg
// Shared types and constants for the pulse-width gesture decoder: register
// indexes, reset values, gesture state codes and the structs between modules.
// ----------------------------------------------------------------------------
package pwgd_pkg;

  // Field widths
  localparam int WidthW = 16;
  localparam int TimeW  = 32;
  localparam int IdxW   = 8;
  localparam int StateW = 3;
  localparam int CfgAW  = 3;
  localparam int CfgDW  = 16;

  // Register indexes on the configuration port
  localparam logic [CfgAW-1:0] REG_LOW_THRESHOLD  = 3'd0;
  localparam logic [CfgAW-1:0] REG_HIGH_THRESHOLD = 3'd1;
  localparam logic [CfgAW-1:0] REG_TIMEOUT_MS     = 3'd2;
  localparam logic [CfgAW-1:0] REG_COLOR_COUNT    = 3'd3;
  localparam logic [CfgAW-1:0] REG_MODE_COUNT     = 3'd4;
  localparam logic [CfgAW-1:0] REG_COLOR_START    = 3'd5;
  localparam logic [CfgAW-1:0] REG_MODE_START     = 3'd6;

  // Register reset values
  localparam logic [WidthW-1:0] RST_LOW_THRESHOLD  = 16'd1400;
  localparam logic [WidthW-1:0] RST_HIGH_THRESHOLD = 16'd1600;
  localparam logic [WidthW-1:0] RST_TIMEOUT_MS     = 16'd500;
  localparam logic [IdxW-1:0]   RST_COLOR_COUNT    = 8'd8;
  localparam logic [IdxW-1:0]   RST_MODE_COUNT     = 8'd8;
  localparam logic [IdxW-1:0]   RST_COLOR_START    = 8'd0;
  localparam logic [IdxW-1:0]   RST_MODE_START     = 8'd0;

  // Gesture state codes
  localparam logic [StateW-1:0] ST_IDLE  = 3'd0;
  localparam logic [StateW-1:0] ST_LOW1  = 3'd1;
  localparam logic [StateW-1:0] ST_HIGH1 = 3'd2;
  localparam logic [StateW-1:0] ST_LOW2  = 3'd3;
  localparam logic [StateW-1:0] ST_HIGH2 = 3'd4;

  typedef struct packed {
    logic [WidthW-1:0] low_threshold;
    logic [WidthW-1:0] high_threshold;
    logic [WidthW-1:0] timeout_ms;
    logic [IdxW-1:0]   color_count;
    logic [IdxW-1:0]   mode_count;
  } cfg_t;

  typedef struct packed {
    logic [StateW-1:0] gesture;
    logic [TimeW-1:0]  last_time;
    logic [IdxW-1:0]   color;
    logic [IdxW-1:0]   mode;
  } gst_t;

endpackage

FILE: sv/pulse_width_gesture_decoder_core.sv
// An accepted input beat feeds the step logic from the input register, and the
// outcome lands in the result register. Throughput: one poll per cycle while
// the result slot is free or being drained; the gesture state and both indices
// update in a single pass of the step logic, so polls may follow back to back.
// Reset (synchronous, rst_n low): registers return to their defaults, the
// gesture machine goes idle, step time clears and indices load the start values.
// ----------------------------------------------------------------------------
// pulse_width_gesture_decoder_core
// Switch gesture decoder on polled RC pulse widths, with a write-only
// configuration port and valid/ready input and result channels.
// ----------------------------------------------------------------------------
module pulse_width_gesture_decoder_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [pwgd_pkg::CfgAW-1:0]     cfg_index,
  input  logic [pwgd_pkg::CfgDW-1:0]     cfg_wdata,
  // poll beats
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pwgd_pkg::WidthW-1:0]    in_pulse_width,
  input  logic [pwgd_pkg::TimeW-1:0]     in_now_ms,
  // result beats
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pwgd_pkg::IdxW-1:0]      out_color_index,
  output logic [pwgd_pkg::IdxW-1:0]      out_mode_index,
  output logic                           out_save_request
);

  pwgd_pkg::cfg_t                  cfg_r;
  pwgd_pkg::gst_t                  st_r;
  pwgd_pkg::gst_t                  st_nxt;
  pwgd_pkg::gst_t                  step_st;
  logic                            save_nxt;
  logic                            advance;
  logic                            s1_valid_r;
  logic [pwgd_pkg::WidthW-1:0]     s1_width_r;
  logic [pwgd_pkg::TimeW-1:0]      s1_now_r;
  logic                            out_valid_r;
  logic [pwgd_pkg::IdxW-1:0]       out_color_r;
  logic [pwgd_pkg::IdxW-1:0]       out_mode_r;
  logic                            out_save_r;

  // Move the whole pipe whenever the result slot is free or being drained
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_threshold  <= pwgd_pkg::RST_LOW_THRESHOLD;
      cfg_r.high_threshold <= pwgd_pkg::RST_HIGH_THRESHOLD;
      cfg_r.timeout_ms     <= pwgd_pkg::RST_TIMEOUT_MS;
      cfg_r.color_count    <= pwgd_pkg::RST_COLOR_COUNT;
      cfg_r.mode_count     <= pwgd_pkg::RST_MODE_COUNT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pwgd_pkg::REG_LOW_THRESHOLD:  cfg_r.low_threshold  <= cfg_wdata;
        pwgd_pkg::REG_HIGH_THRESHOLD: cfg_r.high_threshold <= cfg_wdata;
        pwgd_pkg::REG_TIMEOUT_MS:     cfg_r.timeout_ms     <= cfg_wdata;
        pwgd_pkg::REG_COLOR_COUNT:    cfg_r.color_count    <= cfg_wdata[pwgd_pkg::IdxW-1:0];
        pwgd_pkg::REG_MODE_COUNT:     cfg_r.mode_count     <= cfg_wdata[pwgd_pkg::IdxW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      s1_width_r <= in_pulse_width;
      s1_now_r   <= in_now_ms;
    end
  end

  pwgd_step u_step (
    .cfg         (cfg_r),
    .cur         (st_r),
    .pulse_width (s1_width_r),
    .now_ms      (s1_now_r),
    .nxt         (step_st),
    .save        (save_nxt)
  );

  // Next gesture state; a start write restores the index at once
  always_comb begin
    st_nxt = st_r;
    if (advance && s1_valid_r) begin
      st_nxt = step_st;
    end
    if (cfg_wr_en && cfg_index == pwgd_pkg::REG_COLOR_START) begin
      st_nxt.color = cfg_wdata[pwgd_pkg::IdxW-1:0];
    end
    if (cfg_wr_en && cfg_index == pwgd_pkg::REG_MODE_START) begin
      st_nxt.mode = cfg_wdata[pwgd_pkg::IdxW-1:0];
    end
  end

  // Gesture state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.gesture   <= pwgd_pkg::ST_IDLE;
      st_r.last_time <= '0;
      st_r.color     <= pwgd_pkg::RST_COLOR_START;
      st_r.mode      <= pwgd_pkg::RST_MODE_START;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_color_r <= step_st.color;
      out_mode_r  <= step_st.mode;
      out_save_r  <= save_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_color_index  = out_color_r;
  assign out_mode_index   = out_mode_r;
  assign out_save_request = out_save_r;

`ifndef SYNTHESIS
  // A stalled result beat is never dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("result beat lost while stalled");

  // A poll in the input register waits while the result slot is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_now_r) && $stable(s1_width_r))
    else $error("buffered poll changed while stalled");

  // Gesture state only moves when a poll is processed
  a_state_still: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && s1_valid_r) |=> $stable(st_r.gesture) && $stable(st_r.last_time))
    else $error("gesture state moved without a poll");

  // Every index advance leaves the machine idle
  a_save_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_save_r |-> st_r.gesture == pwgd_pkg::ST_IDLE)
    else $error("save request without return to idle");
`endif

endmodule

FILE: sv/pwgd_step.sv
// ----------------------------------------------------------------------------
// pwgd_step
// Next-state logic for one poll: level classification, step timeout and
// index advance with wrap.
// ----------------------------------------------------------------------------
module pwgd_step (
  input  pwgd_pkg::cfg_t                   cfg,
  input  pwgd_pkg::gst_t                   cur,
  input  logic [pwgd_pkg::WidthW-1:0]      pulse_width,
  input  logic [pwgd_pkg::TimeW-1:0]       now_ms,
  output pwgd_pkg::gst_t                   nxt,
  output logic                             save
);

  logic                          is_low;
  logic                          is_high;
  logic                          expired;
  logic [pwgd_pkg::TimeW-1:0]    elapsed;
  logic [pwgd_pkg::IdxW:0]       color_inc;
  logic [pwgd_pkg::IdxW:0]       mode_inc;
  logic [pwgd_pkg::IdxW-1:0]     color_wrap;
  logic [pwgd_pkg::IdxW-1:0]     mode_wrap;

  // Classify the width and measure the gap since the last step
  assign is_low  = pulse_width < cfg.low_threshold;
  assign is_high = pulse_width > cfg.high_threshold;
  assign elapsed = now_ms - cur.last_time;
  assign expired = elapsed > {{(pwgd_pkg::TimeW-pwgd_pkg::WidthW){1'b0}}, cfg.timeout_ms};

  // Advance each index, wrapping to zero at or past its count
  assign color_inc  = {1'b0, cur.color} + 1'b1;
  assign mode_inc   = {1'b0, cur.mode} + 1'b1;
  assign color_wrap = (color_inc >= {1'b0, cfg.color_count}) ? '0
                                                             : color_inc[pwgd_pkg::IdxW-1:0];
  assign mode_wrap  = (mode_inc >= {1'b0, cfg.mode_count}) ? '0
                                                           : mode_inc[pwgd_pkg::IdxW-1:0];

  // Gesture sequencer
  always_comb begin
    nxt  = cur;
    save = 1'b0;
    unique case (cur.gesture)
      pwgd_pkg::ST_IDLE: begin
        if (is_low) begin
          nxt.gesture   = pwgd_pkg::ST_LOW1;
          nxt.last_time = now_ms;
        end
      end
      pwgd_pkg::ST_LOW1: begin
        if (is_high) begin
          nxt.gesture   = pwgd_pkg::ST_HIGH1;
          nxt.last_time = now_ms;
        end else if (expired) begin
          nxt.gesture = pwgd_pkg::ST_IDLE;
        end
      end
      pwgd_pkg::ST_HIGH1: begin
        if (is_low) begin
          nxt.gesture   = pwgd_pkg::ST_LOW2;
          nxt.last_time = now_ms;
        end else if (expired) begin
          nxt.gesture = pwgd_pkg::ST_IDLE;
        end
      end
      pwgd_pkg::ST_LOW2: begin
        if (is_high) begin
          nxt.gesture   = pwgd_pkg::ST_HIGH2;
          nxt.last_time = now_ms;
        end else if (expired) begin
          // short gesture timed out: next colour
          nxt.gesture = pwgd_pkg::ST_IDLE;
          nxt.color   = color_wrap;
          save        = 1'b1;
        end
      end
      pwgd_pkg::ST_HIGH2: begin
        if (is_low) begin
          // full gesture: next mode
          nxt.gesture   = pwgd_pkg::ST_IDLE;
          nxt.last_time = now_ms;
          nxt.mode      = mode_wrap;
          save          = 1'b1;
        end else if (expired) begin
          nxt.gesture = pwgd_pkg::ST_IDLE;
        end
      end
      default: begin
        nxt.gesture = pwgd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: bench/pulse_width_gesture_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_gesture_decoder_core_tb
// Self-checking bench for the gesture decoder. Polls are driven as colour
// gestures, mode gestures, broken gestures and noise under several register
// settings. A scoreboard tracks the gesture machine and both indices, and
// checks every result beat against the oldest prediction. Both channels idle
// at random, and there are two long result-side holds.
// ----------------------------------------------------------------------------
module pulse_width_gesture_decoder_core_tb;

  typedef logic [pwgd_pkg::WidthW-1:0] width_t;
  typedef logic [pwgd_pkg::TimeW-1:0]  stamp_t;
  typedef logic [pwgd_pkg::IdxW-1:0]   idx_t;
  typedef logic [pwgd_pkg::StateW-1:0] state_t;
  typedef logic [pwgd_pkg::CfgAW-1:0]  regidx_t;
  typedef logic [pwgd_pkg::CfgDW-1:0]  word_t;

  localparam regidx_t REG_SPARE = 3'd7;  // unmapped index, writes ignored
  localparam int N_DIRECTED = 22;

  typedef struct packed {
    idx_t color;
    idx_t mode;
    logic save;
  } poll_result_t;

  typedef struct packed {
    word_t low;
    word_t high;
    word_t timeout;
    word_t color_count;
    word_t mode_count;
    word_t color_start;
    word_t mode_start;
  } reg_plan_t;

  typedef enum {LVL_LOW, LVL_HIGH, LVL_MID, LVL_ANY} level_t;

  // Tracks the gesture machine and holds the results still owed by the block
  class gesture_scoreboard_t;
    width_t       low_thr, high_thr, step_timeout;
    idx_t         color_cnt, mode_cnt;
    state_t       gesture;
    stamp_t       last_step;
    idx_t         color_idx, mode_idx;
    poll_result_t due_outputs[$];
    int           errors;

    function new();
      low_thr      = pwgd_pkg::RST_LOW_THRESHOLD;
      high_thr     = pwgd_pkg::RST_HIGH_THRESHOLD;
      step_timeout = pwgd_pkg::RST_TIMEOUT_MS;
      color_cnt    = pwgd_pkg::RST_COLOR_COUNT;
      mode_cnt     = pwgd_pkg::RST_MODE_COUNT;
      gesture      = pwgd_pkg::ST_IDLE;
      last_step    = '0;
      color_idx    = pwgd_pkg::RST_COLOR_START;
      mode_idx     = pwgd_pkg::RST_MODE_START;
      errors       = 0;
    endfunction

    function void write_reg(regidx_t idx, word_t data);
      case (idx)
        pwgd_pkg::REG_LOW_THRESHOLD:  low_thr = data;
        pwgd_pkg::REG_HIGH_THRESHOLD: high_thr = data;
        pwgd_pkg::REG_TIMEOUT_MS:     step_timeout = data;
        pwgd_pkg::REG_COLOR_COUNT:    color_cnt = data[pwgd_pkg::IdxW-1:0];
        pwgd_pkg::REG_MODE_COUNT:     mode_cnt = data[pwgd_pkg::IdxW-1:0];
        pwgd_pkg::REG_COLOR_START:    color_idx = data[pwgd_pkg::IdxW-1:0];
        pwgd_pkg::REG_MODE_START:     mode_idx = data[pwgd_pkg::IdxW-1:0];
        default: ;
      endcase
    endfunction

    // A step that reaches or passes the count, or from the top code, wraps to zero
    function idx_t wrap_next(idx_t value, idx_t count);
      logic [pwgd_pkg::IdxW:0] n;
      n = {1'b0, value} + 1'b1;
      return (n >= {1'b0, count}) ? '0 : n[pwgd_pkg::IdxW-1:0];
    endfunction

    // Advance the machine by one poll and queue the result it must give
    function void note_poll(width_t width, stamp_t now);
      logic         is_low, is_high, expired, save;
      stamp_t       gap;
      poll_result_t res;
      is_low  = width < low_thr;
      is_high = width > high_thr;
      gap     = now - last_step;
      expired = gap > {16'd0, step_timeout};
      save    = 1'b0;
      case (gesture)
        pwgd_pkg::ST_IDLE: begin
          if (is_low) begin
            gesture = pwgd_pkg::ST_LOW1;
            last_step = now;
          end
        end
        pwgd_pkg::ST_LOW1: begin
          if (is_high) begin
            gesture = pwgd_pkg::ST_HIGH1;
            last_step = now;
          end else if (expired) gesture = pwgd_pkg::ST_IDLE;
        end
        pwgd_pkg::ST_HIGH1: begin
          if (is_low) begin
            gesture = pwgd_pkg::ST_LOW2;
            last_step = now;
          end else if (expired) gesture = pwgd_pkg::ST_IDLE;
        end
        pwgd_pkg::ST_LOW2: begin
          if (is_high) begin
            gesture = pwgd_pkg::ST_HIGH2;
            last_step = now;
          end else if (expired) begin
            color_idx = wrap_next(color_idx, color_cnt);
            save = 1'b1;
            gesture = pwgd_pkg::ST_IDLE;
          end
        end
        pwgd_pkg::ST_HIGH2: begin
          if (is_low) begin
            mode_idx = wrap_next(mode_idx, mode_cnt);
            save = 1'b1;
            last_step = now;
            gesture = pwgd_pkg::ST_IDLE;
          end else if (expired) gesture = pwgd_pkg::ST_IDLE;
        end
        default: gesture = pwgd_pkg::ST_IDLE;
      endcase
      res.color = color_idx;
      res.mode  = mode_idx;
      res.save  = save;
      due_outputs.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(idx_t color, idx_t mode, logic save);
      poll_result_t want;
      if (due_outputs.size() == 0) begin
        report("result beat with nothing outstanding");
        return;
      end
      want = due_outputs.pop_front();
      if (color !== want.color)
        report($sformatf("colour index got %0d want %0d", color, want.color));
      if (mode !== want.mode)
        report($sformatf("mode index got %0d want %0d", mode, want.mode));
      if (save !== want.save)
        report($sformatf("save request got %b want %b", save, want.save));
    endtask

    function int pending();
      return due_outputs.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  regidx_t             cfg_index;
  word_t               cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  width_t              in_pulse_width;
  stamp_t              in_now_ms;
  logic                out_valid;
  logic                out_ready;
  idx_t                out_color_index;
  idx_t                out_mode_index;
  logic                out_save_request;

  gesture_scoreboard_t sb;
  stamp_t              clock_ms;
  int                  sent;
  bit                  quiet;
  bit                  long_hold;

  // Directed polls: width and time step since the previous poll
  int unsigned dir_width [N_DIRECTED] = '{
    65535, 0, 1500, 1601, 1399, 1400, 1400,
    1000, 2000, 1000, 65535, 1399,
    0, 1500,
    100, 1700, 1600,
    10, 60000, 10, 60000, 1500};
  int unsigned dir_delta [N_DIRECTED] = '{
    0, 10, 10, 10, 10, 500, 1,
    5, 5, 5, 5, 5,
    3, 501,
    3, 3, 600,
    3, 3, 3, 3, 800};

  pulse_width_gesture_decoder_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pulse_width   (in_pulse_width),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_color_index  (out_color_index),
    .out_mode_index   (out_mode_index),
    .out_save_request (out_save_request)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_poll(in_pulse_width, in_now_ms);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_color_index, out_mode_index, out_save_request);
  end

  // Result side: random stall bursts, plus one long hold on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        stall_left = 40;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one poll beat and hold it until accepted
  task automatic send_poll(input width_t width, input stamp_t now);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_pulse_width <= width;
    in_now_ms      <= now;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic poll_at(input width_t width, input int unsigned delta);
    clock_ms += delta;
    send_poll(width, clock_ms);
    sent++;
  endtask

  // Width for a switch level under the current thresholds, edges now and then
  function automatic width_t pick_width(level_t lvl);
    width_t lo, hi;
    lo = sb.low_thr;
    hi = sb.high_thr;
    case (lvl)
      LVL_LOW: begin
        if (lo == 0) return width_t'($urandom);
        if ($urandom_range(0, 7) == 0) return lo - 1'b1;
        return width_t'($urandom_range(0, lo - 1));
      end
      LVL_HIGH: begin
        if (hi == 16'hFFFF) return width_t'($urandom);
        if ($urandom_range(0, 7) == 0) return hi + 1'b1;
        return width_t'($urandom_range(hi + 1, 16'hFFFF));
      end
      LVL_MID: begin
        if (lo > hi) return width_t'($urandom);
        case ($urandom_range(0, 7))
          0: return lo;
          1: return hi;
          default: return width_t'($urandom_range(lo, hi));
        endcase
      end
      default: begin
        case ($urandom_range(0, 5))
          0: return 16'h0000;
          1: return 16'hFFFF;
          default: return width_t'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic poll(input level_t lvl, input int unsigned delta);
    poll_at(pick_width(lvl), delta);
  endtask

  function automatic int unsigned short_gap();
    return $urandom_range(0, sb.step_timeout / 4);
  endfunction

  function automatic int unsigned expired_gap();
    return sb.step_timeout + $urandom_range(1, 1000);
  endfunction

  // One gesture: colour, mode, broken, or a short run of noise
  task automatic run_gesture();
    int unsigned kind, steps;
    level_t      want, prev;
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 30) == 0)
      clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    if (kind >= 8) begin
      repeat ($urandom_range(1, 4))
        poll(LVL_ANY, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000));
      return;
    end
    steps = (kind < 4) ? 3 : (kind < 7) ? 5 : $urandom_range(1, 4);
    for (int s = 0; s < steps; s++) begin
      want = s[0] ? LVL_HIGH : LVL_LOW;
      prev = s[0] ? LVL_LOW : LVL_HIGH;
      // switch held, or sitting between levels, before the next step
      if (s > 0 && $urandom_range(0, 2) == 0)
        poll($urandom_range(0, 1) ? prev : LVL_MID, short_gap());
      poll(want, short_gap());
    end
    // let a colour or broken gesture run out
    if (steps < 5) begin
      want = steps[0] ? LVL_LOW : LVL_HIGH;
      poll($urandom_range(0, 1) ? want : LVL_MID, expired_gap());
    end
  endtask

  task automatic write_reg(input regidx_t idx, input word_t data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(input reg_plan_t p);
    write_reg(pwgd_pkg::REG_LOW_THRESHOLD, p.low);
    write_reg(pwgd_pkg::REG_HIGH_THRESHOLD, p.high);
    write_reg(pwgd_pkg::REG_TIMEOUT_MS, p.timeout);
    write_reg(pwgd_pkg::REG_COLOR_COUNT, p.color_count);
    write_reg(pwgd_pkg::REG_MODE_COUNT, p.mode_count);
    write_reg(pwgd_pkg::REG_COLOR_START, p.color_start);
    write_reg(pwgd_pkg::REG_MODE_START, p.mode_start);
    if ($urandom_range(0, 1)) write_reg(REG_SPARE, word_t'($urandom));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Drop valid and wait for every owed result, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Plausible switch settings; upper bits of 8-bit registers are junk
  function automatic reg_plan_t sane_plan(int unsigned max_count);
    reg_plan_t p;
    p.low         = word_t'($urandom_range(200, 3000));
    p.high        = p.low + word_t'($urandom_range(0, 1500));
    p.timeout     = word_t'($urandom_range(5, 2000));
    p.color_count = word_t'(($urandom & 16'hFF00) | $urandom_range(1, max_count));
    p.mode_count  = word_t'(($urandom & 16'hFF00) | $urandom_range(1, max_count));
    p.color_start = word_t'($urandom);
    p.mode_start  = word_t'($urandom);
    return p;
  endfunction

  task automatic run_phase(input reg_plan_t p, input int n_polls, input bit hold);
    int target;
    drain();
    program_regs(p);
    if (hold) long_hold = 1'b1;
    target = sent + n_polls;
    while (sent < target) run_gesture();
  endtask

  initial begin
    reg_plan_t p;
    sb             = new();
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_pulse_width = '0;
    in_now_ms      = '0;
    clock_ms       = 32'd1000;
    sent           = 0;
    quiet          = 1'b0;
    long_hold      = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: thresholds, exact timeout edge, every state timing out
    for (int i = 0; i < N_DIRECTED; i++) poll_at(width_t'(dir_width[i]), dir_delta[i]);
    // gesture across the timestamp wrap
    clock_ms = 32'hFFFF_FFF0;
    poll_at(16'd0, 0);
    poll_at(16'd2000, 32'h20);
    poll_at(16'd0, 4);
    poll_at(16'd1500, 600);

    p = sane_plan(255);
    run_phase(p, 120, 1'b1);

    // Widths 1-65534 low and high, zero timeout, top colour count and mode start
    p = '{low: 16'hFFFF, high: 16'h0000, timeout: 16'h0000, color_count: 16'hA5FF,
          mode_count: 16'h5A01, color_start: 16'h00FE, mode_start: 16'hFFFF};
    run_phase(p, 100, 1'b0);

    // Zero counts send both indices to zero on any advance; longest timeout
    p = '{low: 16'd1400, high: 16'd1600, timeout: 16'hFFFF, color_count: 16'hFF00,
          mode_count: 16'h0000, color_start: 16'h00FF, mode_start: 16'h7F80};
    run_phase(p, 100, 1'b0);

    // Nothing counts as low, so the machine never arms
    p = '{low: 16'h0000, high: 16'hFFFF, timeout: 16'd100, color_count: 16'd4,
          mode_count: 16'd4, color_start: 16'd3, mode_start: 16'd2};
    run_phase(p, 25, 1'b0);

    p = sane_plan(3);
    run_phase(p, 120, 1'b1);

    p = '{low: pwgd_pkg::RST_LOW_THRESHOLD, high: pwgd_pkg::RST_HIGH_THRESHOLD,
          timeout: pwgd_pkg::RST_TIMEOUT_MS,
          color_count: word_t'(pwgd_pkg::RST_COLOR_COUNT),
          mode_count: word_t'(pwgd_pkg::RST_MODE_COUNT),
          color_start: word_t'(pwgd_pkg::RST_COLOR_START),
          mode_start: word_t'(pwgd_pkg::RST_MODE_START)};
    run_phase(p, 120, 1'b0);

    // Last stretch with no idling on either side
    quiet = 1'b1;
    p = sane_plan(255);
    run_phase(p, 120, 1'b0);

    drain();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
